>>> rtl/swf_pkg.sv
// Shared types and constants for the sliding window framer.
// No dependencies; used by swf_ctrl, swf_datapath and sliding_window_framer.
`default_nettype none

package swf_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(64);
    localparam logic [CFG_W-1:0] STEP_RESET   = CFG_W'(32);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE = 1'b0,
        CFG_STEP_SIZE   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic accept_in;
        logic start_window;
        logic issue_read;
    } swf_cmd_t;

    typedef struct packed {
        logic window_due;
        logic read_ok;
        logic read_last;
    } swf_status_t;

endpackage

`default_nettype wire

>>> rtl/sliding_window_framer.sv
// Sliding window framer top level: controller plus datapath.
// The first item of a window reaches the outputs after the sample that
// completes a hop, via the emit state, ring read and output registers.
// Throughput: a window of W items streams at one item per cycle unless
// out_stall is high; intake stalls during read-out (single ring read port).
// Reset: ring reads as zero via per-entry valid flops; no clearing pass.
// Depends on swf_pkg, swf_ctrl and swf_datapath.
`default_nettype none

module sliding_window_framer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [swf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [swf_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [swf_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [swf_pkg::SAMPLE_BITS-1:0]      window_sample,
    output logic [swf_pkg::PTR_W-1:0]            position,
    output logic                                 last_of_window
);

    swf_pkg::swf_cmd_t    cmd;
    swf_pkg::swf_status_t sts;

    swf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    swf_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample         (sample),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .window_sample  (window_sample),
        .position       (position),
        .last_of_window (last_of_window)
    );

    a_due_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && sts.window_due |=> in_stall)
        else $error("intake not stalled after a completed hop");

    a_read_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_read |-> in_stall && !cmd.accept_in)
        else $error("ring read issued while taking samples");

    a_start_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_window |-> cmd.accept_in)
        else $error("window started without an accepted sample");

endmodule

`default_nettype wire

>>> rtl/swf_ctrl.sv
// Controller for the sliding window framer: sample intake and window read-out.
// Depends on swf_pkg.
`default_nettype none

module swf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire swf_pkg::swf_status_t sts,
    output swf_pkg::swf_cmd_t         cmd
);

    swf_pkg::state_t state_reg;
    swf_pkg::state_t state_next;

    always_comb
    begin
        state_next       = state_reg;
        in_stall         = 1'b1;
        cmd.accept_in    = 1'b0;
        cmd.start_window = 1'b0;
        cmd.issue_read   = 1'b0;
        unique case (state_reg)
            swf_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.accept_in = in_valid;
                if (in_valid && sts.window_due)
                begin
                    cmd.start_window = 1'b1;
                    state_next       = swf_pkg::ST_EMIT;
                end
            end
            swf_pkg::ST_EMIT:
            begin
                cmd.issue_read = sts.read_ok;
                if (sts.read_ok && sts.read_last)
                begin
                    state_next = swf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/swf_datapath.sv
// Datapath for the sliding window framer: config registers, sample ring,
// hop counter, read pipeline and output register. Depends on swf_pkg.
`default_nettype none

module swf_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [swf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [swf_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic [swf_pkg::SAMPLE_BITS-1:0]     sample,
    input  wire swf_pkg::swf_cmd_t                   cmd,
    output swf_pkg::swf_status_t                     sts,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [swf_pkg::SAMPLE_BITS-1:0]          window_sample,
    output logic [swf_pkg::PTR_W-1:0]                position,
    output logic                                     last_of_window
);

    localparam int PW = swf_pkg::PTR_W;
    localparam int CW = swf_pkg::CFG_W;
    localparam int SW = PW + 2;
    localparam logic [CW-1:0] MAXW = CW'(swf_pkg::MAX_WINDOW);
    localparam logic [SW-1:0] MAXS = SW'(swf_pkg::MAX_WINDOW);

    logic [CW-1:0] window_size_reg;
    logic [CW-1:0] step_size_reg;
    logic [CW-1:0] win_len;
    logic [CW-1:0] hop_len;

    logic [swf_pkg::SAMPLE_BITS-1:0] ring_mem [swf_pkg::MAX_WINDOW];
    logic [swf_pkg::MAX_WINDOW-1:0]  ring_vld_reg;

    logic [PW-1:0] wp_reg;
    logic [PW-1:0] wp_next;
    logic [CW-1:0] hop_reg;
    logic [CW-1:0] hop_inc;
    logic [PW-1:0] base_reg;
    logic [PW-1:0] base_next;
    logic [SW-1:0] base_sum;
    logic [PW-1:0] k_reg;
    logic [PW-1:0] rd_addr;
    logic [SW-1:0] addr_sum;

    logic [swf_pkg::SAMPLE_BITS-1:0] rd_data_reg;
    logic                            rd_vld_reg;
    logic [PW-1:0]                   rd_pos_reg;
    logic                            rd_last_reg;
    logic                            rd_pend_reg;
    logic                            rd_pend_next;
    logic                            move;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [swf_pkg::SAMPLE_BITS-1:0] out_sample_reg;
    logic [PW-1:0]                   out_pos_reg;
    logic                            out_last_reg;

    // effective window and hop
    always_comb
    begin
        win_len = window_size_reg;
        if (window_size_reg == '0)
        begin
            win_len = CW'(1);
        end
        else if (window_size_reg > MAXW)
        begin
            win_len = MAXW;
        end
        hop_len = step_size_reg;
        if (step_size_reg == '0)
        begin
            hop_len = CW'(1);
        end
        else if (step_size_reg > win_len)
        begin
            hop_len = win_len;
        end
    end

    always_comb
    begin
        if (wp_reg == PW'(swf_pkg::MAX_WINDOW - 1))
        begin
            wp_next = '0;
        end
        else
        begin
            wp_next = wp_reg + PW'(1);
        end
        hop_inc  = hop_reg + CW'(1);
        base_sum = SW'(wp_next) + MAXS - SW'(win_len);
        if (base_sum >= MAXS)
        begin
            base_next = PW'(base_sum - MAXS);
        end
        else
        begin
            base_next = PW'(base_sum);
        end
        addr_sum = SW'(base_reg) + SW'(k_reg);
        if (addr_sum >= MAXS)
        begin
            rd_addr = PW'(addr_sum - MAXS);
        end
        else
        begin
            rd_addr = PW'(addr_sum);
        end
    end

    assign move           = rd_pend_reg && (!out_valid_reg || !out_stall);
    assign rd_pend_next   = cmd.issue_read || (rd_pend_reg && !move);
    assign out_valid_next = move || (out_valid_reg && out_stall);

    assign sts.window_due = (hop_inc >= hop_len);
    assign sts.read_ok    = !rd_pend_reg || move;
    assign sts.read_last  = (k_reg == PW'(win_len - CW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swf_pkg::WINDOW_RESET;
            step_size_reg   <= swf_pkg::STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (swf_pkg::cfg_index_t'(cfg_index))
                swf_pkg::CFG_WINDOW_SIZE: window_size_reg <= cfg_data;
                swf_pkg::CFG_STEP_SIZE:   step_size_reg   <= cfg_data;
                default:                  window_size_reg <= window_size_reg;
            endcase
        end
    end

    // ring store; entries never written read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.accept_in)
        begin
            ring_mem[wp_reg] <= sample;
        end
        if (cmd.issue_read)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
            wp_reg       <= '0;
            hop_reg      <= '0;
        end
        else if (cmd.accept_in)
        begin
            ring_vld_reg[wp_reg] <= 1'b1;
            wp_reg               <= wp_next;
            hop_reg              <= sts.window_due ? '0 : hop_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cmd.start_window)
            begin
                k_reg <= '0;
            end
            else if (cmd.issue_read)
            begin
                k_reg <= k_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_window)
        begin
            base_reg <= base_next;
        end
        if (cmd.issue_read)
        begin
            rd_vld_reg  <= ring_vld_reg[rd_addr];
            rd_pos_reg  <= k_reg;
            rd_last_reg <= sts.read_last;
        end
        if (move)
        begin
            out_sample_reg <= rd_vld_reg ? rd_data_reg : '0;
            out_pos_reg    <= rd_pos_reg;
            out_last_reg   <= rd_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign window_sample  = out_sample_reg;
    assign position       = out_pos_reg;
    assign last_of_window = out_last_reg;

endmodule

`default_nettype wire
